// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each one expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dei_pkg.sv =====
package dei_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 6;
  localparam int IO_DATA_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam int IN_FIELDS_W  = OPCODE_W + POSITION_W + IO_DATA_W;
  localparam int OUT_FIELDS_W = IO_DATA_W + STATUS_W + COUNT_W;
  localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = M_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_READ,
    OP_WRITE,
    OP_REMOVE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_NO_INDEX,
    STAT_FULL
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT
  } state_t;

endpackage

// ===== hw/rtl/dei_ram.sv =====
module dei_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dei_ring_addr.sv =====
module dei_ring_addr #(
  parameter int CAPACITY = 64
) (
  input  logic [$clog2(CAPACITY)-1:0]   base,
  input  logic [$clog2(CAPACITY+1)-1:0] offset,
  output logic [$clog2(CAPACITY)-1:0]   slot
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  // The offset is below the capacity whenever the slot is used, so one
  // conditional subtract brings the sum back into the ring.
  always_comb begin
    sum     = (CW + 1)'(base) + (CW + 1)'(offset);
    wrapped = (sum >= (CW + 1)'(CAPACITY)) ? sum - (CW + 1)'(CAPACITY) : sum;
    slot    = wrapped[AW-1:0];
  end

endmodule

// ===== hw/rtl/double_ended_indexed_buffer_top.sv =====
// Channel  Direction  tdata fields (lowest bit first)
// s_*      in         opcode[2:0], position[8:3], data_in[40:9], zero pad to 48
// m_*      out        read_data[31:0], status[33:32], element_count[40:34], zero pad
//
// Push, write, unused opcodes and rejected requests are answered from the idle state.
// A read passes through ST_READ because the element store has a registered read port.
// A remove at position p stays in ST_SHIFT until each element behind p has moved one
// slot toward the head: the single ring address adder and the store's one read and one
// write port move one element per cycle. Reset empties the store at once; it needs no clearing.
// A result that the receiver has not taken holds off the next request.
`include "assert_macros.svh"

module double_ended_indexed_buffer_top import dei_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // opcode, position, data_in, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // read_data, status, element_count, zero pad
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

  state_t state;
  state_t state_next;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] last_rd;
  logic          pend;

  op_t                   op;
  logic [POSITION_W-1:0] position;
  logic [IO_DATA_W-1:0]  data_in;
  logic                  accept;
  logic                  pos_ok;
  logic                  full;
  logic                  shift_done;

  logic [CW-1:0]         offset;
  logic [AW-1:0]         slot;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                 load_out;
  status_t              res_status;
  logic [IO_DATA_W-1:0] res_data;

  logic                 out_valid;
  status_t              out_status;
  logic [IO_DATA_W-1:0] out_rdata;
  logic [COUNT_W-1:0]   out_count;

  assign op       = op_t'(s_tdata[OPCODE_W-1:0]);
  assign position = s_tdata[OPCODE_W +: POSITION_W];
  assign data_in  = s_tdata[OPCODE_W + POSITION_W +: IO_DATA_W];

  assign s_tready   = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign pos_ok     = PW'(position) < PW'(count);
  assign full       = count == CW'(CAPACITY);
  assign shift_done = rd_idx >= count;

  dei_ring_addr #(
    .CAPACITY(CAPACITY)
  ) u_ring_addr (
    .base  (head),
    .offset(offset),
    .slot  (slot)
  );

  dei_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && pos_ok && op == OP_READ) begin
          state_next = ST_READ;
        end else if (accept && pos_ok && op == OP_REMOVE) begin
          state_next = ST_SHIFT;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SHIFT: begin
        if (shift_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    offset     = CW'(position);
    ram_we     = 1'b0;
    ram_waddr  = slot;
    ram_wdata  = DATA_WIDTH'(data_in);
    load_out   = 1'b0;
    res_status = STAT_OK;
    res_data   = '0;
    head_next  = head;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_HEAD: begin
              offset   = CW'(CAPACITY - 1);
              load_out = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                head_next  = slot;
                count_next = count + CW'(1);
              end
            end
            OP_PUSH_TAIL: begin
              offset   = count;
              load_out = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                res_status = STAT_NO_INDEX;
                load_out   = 1'b1;
              end
            end
            OP_WRITE: begin
              load_out = 1'b1;
              if (pos_ok) begin
                ram_we = 1'b1;
              end else begin
                res_status = STAT_NO_INDEX;
              end
            end
            OP_REMOVE: begin
              if (!pos_ok) begin
                res_status = STAT_NO_INDEX;
                load_out   = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out = 1'b1;
        res_data = IO_DATA_W'(ram_rdata);
      end
      ST_SHIFT: begin
        offset    = rd_idx;
        ram_we    = pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
        if (shift_done) begin
          load_out   = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      pend  <= (state == ST_SHIFT) && !shift_done;
    end
  end

  // The element read from one slot is written into the slot read before it.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && op == OP_REMOVE) begin
      rd_idx  <= CW'(position) + CW'(1);
      wr_addr <= slot;
    end else if (state == ST_SHIFT) begin
      if (!shift_done) begin
        rd_idx  <= rd_idx + CW'(1);
        last_rd <= slot;
      end
      if (pend) begin
        wr_addr <= last_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rdata  <= res_data;
      out_status <= res_status;
      out_count  <= COUNT_W'(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_count, out_status, out_rdata};

  `ASSERT_IMP(a_count_range, 1'b1, count <= CW'(CAPACITY), "element count beyond capacity")
  `ASSERT_NXT(a_read_done, state == ST_READ, state == ST_IDLE && out_valid, "read result lost")
  `ASSERT_NXT(a_push_grow, accept && op == OP_PUSH_TAIL && !full, count == $past(count) + CW'(1), "tail push did not grow the count")
  `ASSERT_NXT(a_shift_end, state == ST_SHIFT && shift_done, count == $past(count) - CW'(1) && out_valid, "remove did not finish cleanly")

endmodule
